[sv/hpet_pkg.sv]
// Package for the HPET-style event timer: item modes, register map, timer config bits
// and the handshake structs of the shared remainder unit.
// No dependencies.
`default_nettype none
package hpet_pkg;
	localparam logic [1:0] MODE_READ  = 2'd0;
	localparam logic [1:0] MODE_WRITE = 2'd1;
	localparam logic [1:0] MODE_TIME  = 2'd2;
	localparam logic [1:0] MODE_NOP   = 2'd3;

	// register word index (byte offset bits 9:3)
	localparam logic [6:0] REG_CAP     = 7'h00;
	localparam logic [6:0] REG_CONFIG  = 7'h02;
	localparam logic [6:0] REG_STATUS  = 7'h04;
	localparam logic [6:0] REG_COUNTER = 7'h1E;

	localparam int TCFG_INT_EN   = 2;
	localparam int TCFG_PERIODIC = 3;
	localparam int TCFG_VAL_SET  = 6;
	localparam logic [63:0] TCFG_CAPS = 64'h00F0_0000_0000_0030;
	localparam logic [63:0] TCFG_VAL_SET_MASK = 64'h0000_0000_0000_0040;

	typedef struct packed {
		logic        start;
		logic [63:0] dividend;
		logic [63:0] divisor;
	} rem_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] rem;
	} rem_rsp_t;

	function automatic logic [63:0] take_part(input logic [63:0] full, input logic hi,
			input logic narrow);
		if (narrow && hi) return {32'd0, full[63:32]};
		if (narrow) return {32'd0, full[31:0]};
		return full;
	endfunction

	function automatic logic [63:0] put_part(input logic [63:0] prev, input logic [63:0] v,
			input logic hi, input logic narrow);
		if (narrow && hi) return {v[31:0], prev[31:0]};
		if (narrow) return {prev[63:32], v[31:0]};
		return v;
	endfunction
endpackage
`default_nettype wire

[sv/hpet_timer_block.sv]
// Top level of the HPET-style event timer: register file, sequencer and timer scan.
// Depends on hpet_pkg and hpet_rem.
//
//  channel | signals                                              | direction
//  --------+------------------------------------------------------+----------
//  in      | in_valid/in_ready, mode, reg_offset, access_is_32,   | into block
//          | write_data, time_now                                 |
//  out     | out_valid/out_ready, read_data, fired_mask           | out of block
//
// A read or write passes through the execute and finish states. A time update goes
// straight to finish when the counter is disabled, through the counter check when the
// counter does not move, else through a scan step per timer, plus a remainder wait and
// an arm step per periodic timer that re-arms. One item is in flight at a time; in_ready is
// high only while the sequencer is idle. The output register holds a result
// until it is taken and a finished item waits for it to drain. Reset clears all
// registers to the documented values at once; no clearing pass.
`default_nettype none
module hpet_timer_block #(
	parameter int NUM_TIMERS = 3,
	parameter int PERIOD_FS  = 69841279
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [1:0]  mode,
	input  wire  [9:0]  reg_offset,
	input  wire         access_is_32,
	input  wire  [63:0] write_data,
	input  wire  [63:0] time_now,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [63:0] read_data,
	output logic [2:0]  fired_mask
);
	import hpet_pkg::*;

	localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EXEC = 3'd1;
	localparam logic [2:0] ST_CHK  = 3'd2;
	localparam logic [2:0] ST_SCAN = 3'd3;
	localparam logic [2:0] ST_WAIT = 3'd4;
	localparam logic [2:0] ST_ARM  = 3'd5;
	localparam logic [2:0] ST_FIN  = 3'd6;

	logic [2:0]  state_q;

	// captured item
	logic [1:0]  mode_q;
	logic [9:0]  off_q;
	logic        n32_q;
	logic [63:0] wd_q;
	logic [63:0] t_q;

	// architectural state
	logic [1:0]            gcfg_q;
	logic [NUM_TIMERS-1:0] irq_q;
	logic [63:0]           main_q;
	logic [63:0]           offs_q;
	logic [63:0]           last_q;
	logic [63:0]           tcfg_q [NUM_TIMERS];
	logic [63:0]           tcmp_q [NUM_TIMERS];
	logic [63:0]           tper_q [NUM_TIMERS];

	// time update working registers
	logic [63:0]           now_q;
	logic [63:0]           before_q;
	logic [63:0]           tmp_q;
	logic [IW-1:0]         idx_q;

	// result
	logic [63:0]           res_rd_q;
	logic [NUM_TIMERS-1:0] res_fired_q;
	logic                  out_valid_q;
	logic [63:0]           out_rd_q;
	logic [NUM_TIMERS-1:0] out_fired_q;

	rem_req_t rem_req;
	rem_rsp_t rem_rsp;

	// register decode of the captured offset
	logic [6:0]  rword;
	logic [9:0]  rel;
	logic [4:0]  tsel;
	logic        tslot_ok;
	logic        is_cmp;
	logic [IW-1:0] ti;
	logic [63:0] cap_word;
	logic [63:0] rd_val;

	assign rword    = off_q[9:3];
	assign rel      = off_q - 10'h100;
	assign tsel     = rel[9:5];
	assign tslot_ok = (off_q[9:8] != 2'b00) && !rel[4] && ({1'b0, tsel} < 6'(NUM_TIMERS));
	assign is_cmp   = rel[3];
	assign ti       = tsel[IW-1:0];

	assign cap_word = {32'(PERIOD_FS), 16'h8086, 1'b1, 1'b0, 1'b1, 5'(NUM_TIMERS - 1), 8'h01};

	always_comb begin
		rd_val = '0;
		case (rword)
			REG_CAP:     rd_val = cap_word;
			REG_CONFIG:  rd_val = {62'd0, gcfg_q};
			REG_STATUS:  rd_val = 64'(irq_q);
			REG_COUNTER: rd_val = main_q;
			default: begin
				if (tslot_ok) rd_val = is_cmp ? tcmp_q[ti] : tcfg_q[ti];
			end
		endcase
	end

	// write merge values
	logic [63:0] wmerge_cfg;
	logic [63:0] wmerge_cmp;
	logic [63:0] wmerge_cnt;
	logic [63:0] wmerge_gc;
	logic [63:0] wmerge_clr;

	assign wmerge_cfg = put_part(tcfg_q[ti], wd_q, off_q[2], n32_q);
	assign wmerge_cmp = put_part(tcmp_q[ti], wd_q, off_q[2], n32_q);
	assign wmerge_cnt = put_part(main_q, wd_q, off_q[2], n32_q);
	assign wmerge_gc  = put_part({62'd0, gcfg_q}, wd_q, off_q[2], n32_q);
	assign wmerge_clr = put_part(64'd0, wd_q, off_q[2], n32_q);

	// timer under scan
	logic [63:0] cur_cmp;
	logic [63:0] cur_cfg;
	logic [63:0] cur_per;
	logic        crossed;
	logic        rearm;
	logic        last_timer;

	assign cur_cmp    = tcmp_q[idx_q];
	assign cur_cfg    = tcfg_q[idx_q];
	assign cur_per    = tper_q[idx_q];
	assign crossed    = (cur_cmp > before_q) && (cur_cmp <= now_q);
	assign rearm      = crossed && cur_cfg[TCFG_PERIODIC] && (cur_per != 64'd0);
	assign last_timer = (idx_q == IW'(NUM_TIMERS - 1));

	// remainder of (now - cmp) / period; next compare is now - rem + period
	assign rem_req.start    = (state_q == ST_SCAN) && rearm;
	assign rem_req.dividend = now_q - cur_cmp;
	assign rem_req.divisor  = cur_per;

	hpet_rem u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rem_req),
		.rsp    (rem_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= '0;
			off_q       <= '0;
			n32_q       <= 1'b0;
			wd_q        <= '0;
			t_q         <= '0;
			gcfg_q      <= '0;
			irq_q       <= '0;
			main_q      <= '0;
			offs_q      <= '0;
			last_q      <= '0;
			now_q       <= '0;
			before_q    <= '0;
			tmp_q       <= '0;
			idx_q       <= '0;
			res_rd_q    <= '0;
			res_fired_q <= '0;
			out_valid_q <= 1'b0;
			out_rd_q    <= '0;
			out_fired_q <= '0;
			for (int i = 0; i < NUM_TIMERS; i++) begin
				tcfg_q[i] <= TCFG_CAPS;
				tcmp_q[i] <= '1;
				tper_q[i] <= '0;
			end
		end else begin
			// drop the result once the consumer takes it, unless a new one replaces it
			if (out_valid_q && out_ready && state_q != ST_FIN) out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						mode_q      <= mode;
						off_q       <= reg_offset;
						n32_q       <= access_is_32;
						wd_q        <= write_data;
						t_q         <= time_now;
						res_rd_q    <= '0;
						res_fired_q <= '0;
						state_q     <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					// only an enabled time update goes on to the counter check
					state_q <= (mode_q == MODE_TIME && gcfg_q[0]) ? ST_CHK : ST_FIN;
					case (mode_q)
						MODE_READ: res_rd_q <= take_part(rd_val, off_q[2], n32_q);
						MODE_WRITE: begin
							case (rword)
								REG_CONFIG: gcfg_q <= wmerge_gc[1:0];
								REG_STATUS: irq_q <= irq_q & ~wmerge_clr[NUM_TIMERS-1:0];
								REG_COUNTER: begin
									main_q <= wmerge_cnt;
									offs_q <= wmerge_cnt - last_q;
								end
								default: begin
									if (tslot_ok && !is_cmp) begin
										tcfg_q[ti] <= (wmerge_cfg & ~(TCFG_CAPS | TCFG_VAL_SET_MASK))
											| TCFG_CAPS | (wmerge_cfg & TCFG_VAL_SET_MASK);
										if (wmerge_cfg[TCFG_VAL_SET]) tper_q[ti] <= '0;
									end else if (tslot_ok) begin
										if (tcfg_q[ti][TCFG_PERIODIC] && tcfg_q[ti][TCFG_VAL_SET]) begin
											tper_q[ti] <= wmerge_cmp;
											tcmp_q[ti] <= main_q + wmerge_cmp;
											tcfg_q[ti] <= tcfg_q[ti] & ~TCFG_VAL_SET_MASK;
										end else begin
											tcmp_q[ti] <= wmerge_cmp;
										end
									end
								end
							endcase
						end
						MODE_TIME: begin
							last_q <= t_q;
							if (gcfg_q[0]) now_q <= t_q + offs_q;
						end
						default: ;
					endcase
				end
				ST_CHK: begin
					if (now_q == main_q) begin
						state_q <= ST_FIN;
					end else begin
						before_q <= main_q;
						main_q   <= now_q;
						idx_q    <= '0;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (crossed && cur_cfg[TCFG_INT_EN]) begin
						irq_q[idx_q]       <= 1'b1;
						res_fired_q[idx_q] <= 1'b1;
					end
					if (rearm) state_q <= ST_WAIT;
					else if (last_timer) state_q <= ST_FIN;
					else idx_q <= idx_q + IW'(1);
				end
				ST_WAIT: begin
					if (rem_rsp.done) begin
						tmp_q   <= now_q - rem_rsp.rem;
						state_q <= ST_ARM;
					end
				end
				ST_ARM: begin
					tcmp_q[idx_q] <= tmp_q + cur_per;
					if (last_timer) state_q <= ST_FIN;
					else begin
						idx_q   <= idx_q + IW'(1);
						state_q <= ST_SCAN;
					end
				end
				ST_FIN: begin
					// hold until the output register is free
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_rd_q    <= res_rd_q;
						out_fired_q <= res_fired_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign read_data = out_rd_q;

	for (genvar b = 0; b < 3; b++) begin : g_fired
		if (b < NUM_TIMERS) begin : g_on
			assign fired_mask[b] = out_fired_q[b];
		end else begin : g_off
			assign fired_mask[b] = 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rem_rsp.done |-> (rem_rsp.rem < cur_per))
		else $error("remainder not below period");

	a_irq_only_scan: assert property (@(posedge clk) disable iff (!arst_n)
		($past(state_q) != ST_SCAN) |-> ((irq_q & ~$past(irq_q)) == '0))
		else $error("interrupt status set outside timer scan");

	a_wait_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_WAIT) |-> $past(rem_req.start))
		else $error("waiting on remainder unit that was not started");
`endif
endmodule
`default_nettype wire

[sv/hpet_rem.sv]
// Bit-serial restoring remainder unit: one quotient bit per cycle.
// Depends on hpet_pkg.
`default_nettype none
module hpet_rem (
	input  wire                clk,
	input  wire                arst_n,
	input  hpet_pkg::rem_req_t req,
	output hpet_pkg::rem_rsp_t rsp
);
	import hpet_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [6:0]  cnt_q;
	logic [64:0] r_q;
	logic [63:0] dq_q;
	logic [63:0] p_q;
	logic [64:0] trial;

	assign trial = {r_q[63:0], dq_q[63]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			r_q    <= '0;
			dq_q   <= '0;
			p_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
				r_q    <= '0;
				dq_q   <= req.dividend;
				p_q    <= req.divisor;
			end else if (busy_q) begin
				// shift in the next dividend bit, subtract when it fits
				if (trial >= {1'b0, p_q}) r_q <= trial - {1'b0, p_q};
				else r_q <= trial;
				dq_q  <= {dq_q[62:0], 1'b0};
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = r_q[63:0];
endmodule
`default_nettype wire

[dv/hpet_timer_block_test.sv]
// Self-checking testbench for hpet_timer_block: reads, writes and time updates
// are checked against an in-bench prediction of the timer's register state.
// Depends on hpet_pkg and the hpet_timer_block RTL.
`timescale 1ns / 1ps
`default_nettype none

import hpet_pkg::*;

typedef struct {
	logic [63:0] rd;
	logic [2:0]  fired;
} hpet_result_t;

class hpet_scoreboard;
	localparam int NT = 3;
	logic [63:0] gen_cfg, irq_stat, counter, cnt_offset, last_t;
	logic [63:0] tcfg [NT];
	logic [63:0] tcmp [NT];
	logic [63:0] tper [NT];
	hpet_result_t pending[$];
	int errors;
	int matched;
	int fires_seen;

	function new();
		errors = 0;
		matched = 0;
		fires_seen = 0;
		gen_cfg = '0;
		irq_stat = '0;
		counter = '0;
		cnt_offset = '0;
		last_t = '0;
		for (int i = 0; i < NT; i++) begin
			tcfg[i] = TCFG_CAPS;
			tcmp[i] = '1;
			tper[i] = '0;
		end
	endfunction

	function logic [63:0] cap_value();
		logic [63:0] c;
		c = 64'h01;
		c[12:8] = 5'(NT - 1);
		c[13] = 1'b1;
		c[15] = 1'b1;
		c[31:16] = 16'h8086;
		c[63:32] = 32'd69841279;
		return c;
	endfunction

	function logic [63:0] slice(logic [63:0] full, logic hi, logic narrow);
		if (narrow && hi) return {32'd0, full[63:32]};
		if (narrow) return {32'd0, full[31:0]};
		return full;
	endfunction

	function logic [63:0] merge(logic [63:0] prev, logic [63:0] v, logic hi, logic narrow);
		if (narrow && hi) return {v[31:0], prev[31:0]};
		if (narrow) return {prev[63:32], v[31:0]};
		return v;
	endfunction

	// decode a timer word; returns -1 for unmapped
	function int timer_idx(logic [9:0] off, output bit is_cmp);
		logic [9:0] rel;
		int idx;
		is_cmp = 0;
		if (off < 10'h100) return -1;
		rel = off - 10'h100;
		idx = rel[9:5];
		if (idx >= NT) return -1;
		if (rel[4:3] == 2'd0) return idx;
		if (rel[4:3] == 2'd1) begin
			is_cmp = 1;
			return idx;
		end
		return -1;
	endfunction

	// note an accepted input and predict its result
	function void note_input(logic [1:0] md, logic [9:0] off, logic n, logic [63:0] wd,
			logic [63:0] tn);
		hpet_result_t r;
		logic [6:0] word;
		logic hi;
		bit is_cmp;
		int idx;
		logic [63:0] w, prev_cnt, now, q;
		r.rd = '0;
		r.fired = '0;
		word = off[9:3];
		hi = off[2];
		idx = timer_idx(off, is_cmp);
		if (md == MODE_READ) begin
			if (word == REG_CAP) r.rd = slice(cap_value(), hi, n);
			else if (word == REG_CONFIG) r.rd = slice(gen_cfg, hi, n);
			else if (word == REG_STATUS) r.rd = slice(irq_stat, hi, n);
			else if (word == REG_COUNTER) r.rd = slice(counter, hi, n);
			else if (idx >= 0) r.rd = slice(is_cmp ? tcmp[idx] : tcfg[idx], hi, n);
		end else if (md == MODE_WRITE) begin
			if (word == REG_CONFIG) gen_cfg = merge(gen_cfg, wd, hi, n) & 64'h3;
			else if (word == REG_STATUS) irq_stat &= ~merge('0, wd, hi, n);
			else if (word == REG_COUNTER) begin
				counter = merge(counter, wd, hi, n);
				cnt_offset = counter - last_t;
			end else if (idx >= 0 && !is_cmp) begin
				w = merge(tcfg[idx], wd, hi, n);
				tcfg[idx] = (w & ~(TCFG_CAPS | TCFG_VAL_SET_MASK)) | TCFG_CAPS;
				if (w[TCFG_VAL_SET]) begin
					tper[idx] = '0;
					tcfg[idx][TCFG_VAL_SET] = 1'b1;
				end
			end else if (idx >= 0) begin
				w = merge(tcmp[idx], wd, hi, n);
				if (tcfg[idx][TCFG_PERIODIC] && tcfg[idx][TCFG_VAL_SET]) begin
					tper[idx] = w;
					tcmp[idx] = counter + w;
					tcfg[idx][TCFG_VAL_SET] = 1'b0;
				end else tcmp[idx] = w;
			end
		end else if (md == MODE_TIME) begin
			last_t = tn;
			now = tn + cnt_offset;
			if (gen_cfg[0] && now != counter) begin
				prev_cnt = counter;
				counter = now;
				for (int i = 0; i < NT; i++) begin
					if (tcmp[i] > prev_cnt && tcmp[i] <= now) begin
						if (tcfg[i][TCFG_INT_EN]) begin
							irq_stat[i] = 1'b1;
							r.fired[i] = 1'b1;
						end
						if (tcfg[i][TCFG_PERIODIC] && tper[i] != 0) begin
							q = (now - tcmp[i]) / tper[i];
							tcmp[i] = tcmp[i] + q * tper[i] + tper[i];
						end
					end
				end
			end
		end
		if (r.fired != 0) fires_seen++;
		pending.push_back(r);
	endfunction

	function void check_result(logic [63:0] rd, logic [2:0] fm);
		hpet_result_t e;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result rd=%h fired=%b", $time, rd, fm);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (rd !== e.rd) begin
			$display("%0t: read_data expected %h actual %h", $time, e.rd, rd);
			errors++;
		end
		if (fm !== e.fired) begin
			$display("%0t: fired_mask expected %b actual %b", $time, e.fired, fm);
			errors++;
		end
		matched++;
	endfunction
endclass

module hpet_timer_block_test;
	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  mode;
	logic [9:0]  reg_offset;
	logic        access_is_32;
	logic [63:0] write_data;
	logic [63:0] time_now;
	logic        out_valid;
	logic        out_ready;
	logic [63:0] read_data;
	logic [2:0]  fired_mask;

	hpet_scoreboard sb;
	longint cycles;
	bit     long_stalls;
	logic [63:0] tick;   // running absolute time for well-formed updates

	hpet_timer_block dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .reg_offset(reg_offset), .access_is_32(access_is_32),
		.write_data(write_data), .time_now(time_now),
		.out_valid(out_valid), .out_ready(out_ready),
		.read_data(read_data), .fired_mask(fired_mask)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// cycle limit: room for the slowest item with stalls, several times over
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 2_000_000) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// mostly short gaps, a few long ones
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// sink side: check at the rising edge, change ready at the falling edge
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) sb.check_result(read_data, fired_mask);
			@(negedge clk);
			if (long_stalls) out_ready = (gap_len() == 0);
			else out_ready = 1'b1;
		end
	end

	// present one transfer and hold it until accepted
	task automatic send_item(logic [1:0] md, logic [9:0] off, logic n, logic [63:0] wd,
			logic [63:0] tn);
		int g;
		g = long_stalls ? gap_len() : 0;
		repeat (g) @(negedge clk);
		in_valid = 1'b1;
		mode = md;
		reg_offset = off;
		access_is_32 = n;
		write_data = wd;
		time_now = tn;
		do @(posedge clk); while (!in_ready);
		sb.note_input(md, off, n, wd, tn);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic rd64(logic [9:0] off);
		send_item(MODE_READ, off, 1'b0, '0, '0);
	endtask

	task automatic wr64(logic [9:0] off, logic [63:0] v);
		send_item(MODE_WRITE, off, 1'b0, v, '0);
	endtask

	task automatic advance(logic [63:0] t);
		send_item(MODE_TIME, '0, 1'b0, '0, t);
	endtask

	// hold the sender until every expected result has drained
	task automatic drain();
		while (sb.pending.size() != 0) @(negedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// offsets biased toward mapped registers
	function automatic logic [9:0] pick_offset();
		logic [9:0] o;
		case ($urandom_range(0, 9))
			0: o = {REG_CAP, 3'b0};
			1: o = {REG_CONFIG, 3'b0};
			2: o = {REG_STATUS, 3'b0};
			3: o = {REG_COUNTER, 3'b0};
			4, 5, 6: o = 10'h100 + 10'($urandom_range(0, 2)) * 10'h20;
			7, 8: o = 10'h108 + 10'($urandom_range(0, 2)) * 10'h20;
			default: o = 10'($urandom_range(0, 1023));
		endcase
		if ($urandom_range(0, 3) == 0) o[2] = 1'b1;
		return o;
	endfunction

	// a periodic timer armed through the VAL_SET sequence
	task automatic arm_periodic(int t);
		logic [9:0] cfg_off, cmp_off;
		logic [63:0] cfg;
		cfg_off = 10'h100 + 10'(t) * 10'h20;
		cmp_off = cfg_off + 10'h8;
		cfg = '0;
		cfg[TCFG_INT_EN] = $urandom_range(0, 4) != 0;
		cfg[TCFG_PERIODIC] = 1'b1;
		cfg[TCFG_VAL_SET] = 1'b1;
		wr64(cfg_off, cfg);
		wr64(cmp_off, 64'($urandom_range(1, 300)));
	endtask

	initial begin
		logic [63:0] v;
		int r;
		sb = new();
		long_stalls = 0;
		tick = '0;
		in_valid = 1'b0;
		mode = MODE_READ;
		reg_offset = '0;
		access_is_32 = 1'b0;
		write_data = '0;
		time_now = '0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset values, halves, mode three, unmapped words
		rd64({REG_CAP, 3'b0});
		send_item(MODE_READ, 10'h004, 1'b1, '0, '0);
		send_item(MODE_READ, 10'h000, 1'b1, '0, '0);
		rd64(10'h100);
		rd64(10'h108);
		rd64(10'h110);
		rd64(10'h160);
		rd64(10'h3F8);
		send_item(MODE_NOP, 10'h3FF, 1'b1, '1, '1);
		advance(64'd50);                       // disabled: only last_time moves
		wr64({REG_CONFIG, 3'b0}, '1);
		rd64({REG_CONFIG, 3'b0});
		wr64({REG_COUNTER, 3'b0}, 64'd100);
		wr64(10'h100, '1);                     // all bits, VAL_SET arm
		wr64(10'h108, 64'd20);
		rd64(10'h108);
		advance(64'd200);                      // several periods in one step
		send_item(MODE_WRITE, 10'h024, 1'b1, '1, '0);
		send_item(MODE_WRITE, 10'h020, 1'b1, 64'hFFFF_FFFF_0000_0007, '0);
		wr64(10'h128, '1);
		wr64(10'h148, 64'hFFFF_FFFF_FFFF_FFF0);
		wr64(10'h140, 64'h4C);                 // periodic near the top: wraps
		advance(64'd10);                       // time goes backwards
		advance('1);
		rd64({REG_STATUS, 3'b0});
		drain();

		// random: mostly well-formed arm/advance sequences with random content
		long_stalls = 1;
		tick = '0;
		for (int n = 0; n < 1650; n++) begin
			r = $urandom_range(0, 99);
			if (n == 800) begin
				drain();
				long_stalls = 0;
			end
			if (n == 1200) long_stalls = 1;
			if (r < 8) begin
				arm_periodic($urandom_range(0, 2));
				n++;
			end else if (r < 40) begin
				if ($urandom_range(0, 19) == 0) tick = rand64();
				else if ($urandom_range(0, 9) == 0) tick = tick - 64'($urandom_range(0, 50));
				else tick = tick + 64'($urandom_range(0, 120));
				advance(tick);
			end else if (r < 45) begin
				wr64({REG_CONFIG, 3'b0}, (rand64() & ~64'h3) | {62'd0,
					$urandom_range(0, 7) != 0, 1'($urandom())});
			end else if (r < 70) begin
				send_item(MODE_READ, pick_offset(), 1'($urandom()), '0, '0);
			end else if (r < 80) begin
				v = rand64();
				if ($urandom_range(0, 1) != 0) v = 64'($urandom_range(0, 500)) + tick;
				send_item(MODE_WRITE, pick_offset(), 1'($urandom()), v, '0);
			end else if (r < 85) begin
				send_item(MODE_WRITE, {REG_STATUS, 3'b0}, 1'($urandom()), rand64(), '0);
			end else begin
				send_item(2'($urandom()), 10'($urandom()), 1'($urandom()), rand64(),
					rand64());
			end
		end

		drain();
		repeat (300) @(posedge clk);
		$display("Checked %0d results, %0d of them time updates that fired timers.",
			sb.matched, sb.fires_seen);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule

`default_nettype wire
